// ----- rtl/sbbg_pkg.sv -----
// ----------------------------------------------------------------------------
// sbbg_pkg
// Shared types, codes and the DAC slot decode for the synth board bus glue.
// ----------------------------------------------------------------------------
package sbbg_pkg;

  localparam int unsigned SBBG_RX_FIFO_DEPTH = 64;
  localparam int unsigned SBBG_CV_SLOTS      = 60;

  // Address decode: region is bus_addr[15:13], I/O block is bus_addr[12:10]
  localparam logic [2:0] REGION_IO     = 3'd0;
  localparam logic [2:0] REGION_PRESET = 3'd1;
  localparam logic [2:0] REGION_EMPTY  = 3'd2;
  localparam logic [2:0] REGION_RAM    = 3'd3;

  localparam logic [2:0] IO_DAC    = 3'd4;
  localparam logic [2:0] IO_STATUS = 3'd5;
  localparam logic [2:0] IO_SWITCH = 3'd6;
  localparam logic [2:0] IO_MISC   = 3'd7;

  localparam logic [2:0] STAT_REG_STATUS = 3'd6;
  localparam logic [2:0] STAT_REG_RX     = 3'd7;
  localparam logic [2:0] MISC_REG_BANK   = 3'd3;

  localparam logic [1:0] SW_SEL_A = 2'd0;
  localparam logic [1:0] SW_SEL_B = 2'd1;

  localparam logic [7:0] STATUS_BASE = 8'h02;

  typedef enum logic [1:0] {
    REQ_READ   = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_MIDI   = 2'd2,
    REQ_UNUSED = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    TGT_INT    = 3'd0,
    TGT_TIMER  = 3'd1,
    TGT_PRESET = 3'd2,
    TGT_RAM    = 3'd3,
    TGT_ROM    = 3'd4,
    TGT_DAC    = 3'd5,
    TGT_LED    = 3'd6,
    TGT_NONE   = 3'd7
  } target_e;

  typedef struct packed {
    target_e     target;
    logic [5:0]  sub_index;
    logic [1:0]  timer_reg;
    logic [15:0] mapped_addr;
    logic [7:0]  rdata;
    logic [11:0] cv_value;
    logic [7:0]  led_value;
    logic        halt_request;
    logic        fault_flag;
    logic        rx_pending;
  } res_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] wdata;
  } fifo_ctl_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    logic       single;
    logic [7:0] head_data;
  } fifo_st_t;

  typedef struct packed {
    logic       en;
    logic [5:0] slot;
  } cv_rd_t;

  typedef struct packed {
    logic        en;
    logic [5:0]  slot;
    logic [11:0] data;
  } cv_wr_t;

  typedef struct packed {
    logic       bad;
    logic [5:0] slot;
  } dac_slot_t;

  // Voice in bits 6:4, channel in bits 3:1; voices 6 and 7 fold onto
  // channels 8 and up of voices 0..5. Channel 10 is out of range.
  function automatic dac_slot_t dac_slot(input logic [15:0] addr);
    logic [2:0] v;
    logic [2:0] c;
    logic [3:0] n;
    logic [2:0] vm;
    logic [1:0] q;
    logic [2:0] vv;
    logic [3:0] cc;
    logic [6:0] s;
    dac_slot_t  r;
    v = addr[6:4];
    c = addr[3:1];
    n = {v[0], c};
    if (n < 4'd6) begin
      q  = 2'd0;
      vm = n[2:0];
    end else if (n < 4'd12) begin
      q  = 2'd1;
      vm = 3'(n - 4'd6);
    end else begin
      q  = 2'd2;
      vm = 3'(n - 4'd12);
    end
    if (v >= 3'd6) begin
      vv = vm;
      cc = 4'd8 + {2'b00, q};
    end else begin
      vv = v;
      cc = {1'b0, c};
    end
    s      = 7'(vv) * 7'd10 + 7'(cc);
    r.bad  = (cc > 4'd9);
    r.slot = s[5:0];
    return r;
  endfunction

endpackage

// ----- rtl/sbbg_rx_fifo.sv -----
// ----------------------------------------------------------------------------
// sbbg_rx_fifo
// MIDI receive FIFO: one-port-write memory with a prefetched head word.
// ----------------------------------------------------------------------------
module sbbg_rx_fifo
  import sbbg_pkg::*;
#(
  parameter int unsigned Depth = SBBG_RX_FIFO_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  fifo_ctl_t ctl_i,
  output fifo_st_t  st_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic [7:0]      mem_q [Depth];
  logic [7:0]      head_data_q;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctl_i.push) begin
      tail_d  = (tail_q == PtrW'(Depth - 1)) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end else if (ctl_i.pop) begin
      head_d  = (head_q == PtrW'(Depth - 1)) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Prefetch the word at the next head; forward a push into that slot.
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem_q[tail_q] <= ctl_i.wdata;
    end
    if (ctl_i.push && (tail_q == head_d)) begin
      head_data_q <= ctl_i.wdata;
    end else begin
      head_data_q <= mem_q[head_d];
    end
  end

  assign st_o.empty     = (count_q == '0);
  assign st_o.full      = (count_q == CntW'(Depth));
  assign st_o.single    = (count_q == CntW'(1));
  assign st_o.head_data = head_data_q;

endmodule

// ----- rtl/sbbg_cv_store.sv -----
// ----------------------------------------------------------------------------
// sbbg_cv_store
// Control voltage store: 60 words of 12 bits, registered read, valid bits.
// ----------------------------------------------------------------------------
module sbbg_cv_store
  import sbbg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cv_rd_t      rd_i,
  input  cv_wr_t      wr_i,
  output logic [11:0] rd_data_o
);

  logic [11:0]              mem_q [SBBG_CV_SLOTS];
  logic [SBBG_CV_SLOTS-1:0] vld_q;
  logic [11:0]              rd_data_q;
  logic                     rd_vld_q;
  logic                     fwd;

  // A write and a read of the same slot in one cycle: take the new word
  assign fwd = wr_i.en && (wr_i.slot == rd_i.slot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.slot] <= 1'b1;
      end
      if (rd_i.en) begin
        rd_vld_q <= fwd ? 1'b1 : vld_q[rd_i.slot];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.slot] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_data_q <= fwd ? wr_i.data : mem_q[rd_i.slot];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ----- rtl/sbbg_decode.sv -----
// ----------------------------------------------------------------------------
// sbbg_decode
// Address decode and result build for one bus word; drives state updates.
// ----------------------------------------------------------------------------
module sbbg_decode
  import sbbg_pkg::*;
(
  input  logic        fire_i,
  input  req_e        req_i,
  input  logic [15:0] addr_i,
  input  logic [7:0]  wdata_i,
  input  logic [7:0]  switch_a_i,
  input  logic [7:0]  switch_b_i,
  input  logic [2:0]  bank_i,
  input  fifo_st_t    fifo_st_i,
  input  logic [11:0] cv_old_i,
  output res_t        res_o,
  output fifo_ctl_t   fifo_ctl_o,
  output cv_wr_t      cv_wr_o,
  output logic        bank_we_o,
  output logic [2:0]  bank_wd_o
);

  logic [2:0] region;
  logic [2:0] io;
  dac_slot_t  ds;
  logic       push_ok;
  logic       pop_ok;

  assign region = addr_i[15:13];
  assign io     = addr_i[12:10];
  assign ds     = dac_slot(addr_i);

  always_comb begin
    res_o     = '0;
    res_o.target = TGT_NONE;
    push_ok   = 1'b0;
    pop_ok    = 1'b0;
    cv_wr_o   = '0;
    bank_we_o = 1'b0;
    bank_wd_o = wdata_i[2:0];

    unique case (req_i)
      REQ_READ: begin
        if (region == REGION_IO) begin
          res_o.target = TGT_INT;
          if (!io[2]) begin
            res_o.target    = TGT_TIMER;
            res_o.sub_index = 6'(io) + 6'd1;
            res_o.timer_reg = addr_i[1:0];
          end else if (io == IO_STATUS) begin
            if (addr_i[9]) begin
              res_o.target    = TGT_TIMER;
              res_o.timer_reg = addr_i[1:0];
            end else if (addr_i[2:0] == STAT_REG_STATUS) begin
              res_o.rdata = STATUS_BASE | {7'd0, !fifo_st_i.empty};
            end else if (addr_i[2:0] == STAT_REG_RX) begin
              if (fifo_st_i.empty) begin
                res_o.fault_flag = 1'b1;
              end else begin
                pop_ok      = 1'b1;
                res_o.rdata = fifo_st_i.head_data;
              end
            end
          end else if (io == IO_SWITCH) begin
            unique case (addr_i[1:0])
              SW_SEL_A: res_o.rdata = switch_a_i;
              SW_SEL_B: res_o.rdata = switch_b_i;
              default:  res_o.rdata = 8'hff;
            endcase
          end
        end else if (region == REGION_PRESET) begin
          res_o.target      = TGT_PRESET;
          res_o.mapped_addr = {bank_i, addr_i[12:0]};
        end else if (region == REGION_EMPTY) begin
          res_o.target = TGT_INT;
        end else if (region == REGION_RAM) begin
          res_o.target      = TGT_RAM;
          res_o.mapped_addr = {1'b0, bank_i[1:0], addr_i[12:0]};
        end else begin
          res_o.target      = TGT_ROM;
          res_o.mapped_addr = addr_i;
        end
      end

      REQ_WRITE: begin
        if (region == REGION_IO) begin
          if (!io[2]) begin
            res_o.target    = TGT_TIMER;
            res_o.sub_index = 6'(io) + 6'd1;
            res_o.timer_reg = addr_i[1:0];
          end else if (io == IO_DAC) begin
            if (ds.bad) begin
              res_o.fault_flag = 1'b1;
            end else begin
              // Even address: upper seven bits; odd address: lower five
              cv_wr_o.en   = 1'b1;
              cv_wr_o.slot = ds.slot;
              cv_wr_o.data = addr_i[0] ? {cv_old_i[11:5], wdata_i[7:3]}
                                       : {wdata_i[6:0], cv_old_i[4:0]};
              res_o.target    = TGT_DAC;
              res_o.sub_index = ds.slot;
              res_o.cv_value  = cv_wr_o.data;
            end
          end else if (io == IO_STATUS) begin
            if (addr_i[9]) begin
              res_o.target    = TGT_TIMER;
              res_o.timer_reg = addr_i[1:0];
            end
          end else if (io == IO_MISC) begin
            if (addr_i[9:7] == MISC_REG_BANK) begin
              bank_we_o = 1'b1;
            end else if (addr_i[9]) begin
              res_o.target    = TGT_LED;
              res_o.sub_index = {4'd0, addr_i[8:7]};
              res_o.led_value = ~wdata_i;
            end
          end
        end else if (region == REGION_PRESET || region == REGION_EMPTY) begin
          res_o.halt_request = 1'b1;
        end else if (region == REGION_RAM) begin
          res_o.target      = TGT_RAM;
          res_o.mapped_addr = {1'b0, bank_i[1:0], addr_i[12:0]};
        end
      end

      REQ_MIDI: begin
        if (fifo_st_i.full) begin
          res_o.fault_flag = 1'b1;
        end else begin
          push_ok = 1'b1;
        end
      end

      default: begin
      end
    endcase

    // Occupancy after this word
    if (push_ok) begin
      res_o.rx_pending = 1'b1;
    end else if (pop_ok) begin
      res_o.rx_pending = !fifo_st_i.single;
    end else begin
      res_o.rx_pending = !fifo_st_i.empty;
    end

    cv_wr_o.en = cv_wr_o.en && fire_i;
    bank_we_o  = bank_we_o && fire_i;
  end

  assign fifo_ctl_o.push  = push_ok && fire_i;
  assign fifo_ctl_o.pop   = pop_ok && fire_i;
  assign fifo_ctl_o.wdata = wdata_i;

endmodule

// ----- rtl/synth_board_bus_glue.sv -----
// ----------------------------------------------------------------------------
// synth_board_bus_glue
// Bus glue of an emulated synth board: address decode, bank mapping, DAC
// control voltage store, LED latch and MIDI receive FIFO.
//
//   channel   direction  handshake              payload
//   in        to block   in_valid_i/in_stall_o  req_type, bus_addr, wdata,
//                                               switch_a, switch_b
//   out       from block out_valid_o/out_stall_i target .. rx_pending
//
// One word per cycle sustained while the result side does not stall. A word
// is accepted into the input register as the DAC store read is issued for
// it, then decode and state updates load the result register. in_stall_o
// rises only while a word waits in the input register behind a stalled
// result. Reset clears the pointers, the bank, the result and input valid
// flags and the DAC store valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module synth_board_bus_glue
  import sbbg_pkg::*;
#(
  parameter int unsigned RX_FIFO_DEPTH = SBBG_RX_FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] bus_addr_i,
  input  logic [7:0]  wdata_i,
  input  logic [7:0]  switch_a_i,
  input  logic [7:0]  switch_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  target_o,
  output logic [5:0]  sub_index_o,
  output logic [1:0]  timer_reg_o,
  output logic [15:0] mapped_addr_o,
  output logic [7:0]  rdata_o,
  output logic [11:0] cv_value_o,
  output logic [7:0]  led_value_o,
  output logic        halt_request_o,
  output logic        fault_flag_o,
  output logic        rx_pending_o
);

  logic        in_valid_q, in_valid_d;
  logic        out_valid_q, out_valid_d;
  logic        in_accept, adv;
  req_e        req_q;
  logic [15:0] addr_q;
  logic [7:0]  wdata_q, sw_a_q, sw_b_q;
  logic [2:0]  bank_q;
  res_t        res_q, res_d;
  fifo_ctl_t   fifo_ctl;
  fifo_st_t    fifo_st;
  cv_rd_t      cv_rd;
  cv_wr_t      cv_wr;
  logic [11:0] cv_old;
  logic        bank_we;
  logic [2:0]  bank_wd;
  dac_slot_t   in_slot;

  // Move the held word into the result register when that register frees up
  assign adv         = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !adv;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_valid_d  = in_accept || (in_valid_q && !adv);
  assign out_valid_d = adv || (out_valid_q && out_stall_i);

  assign in_slot     = dac_slot(bus_addr_i);
  assign cv_rd.en    = in_accept;
  assign cv_rd.slot  = in_slot.slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      bank_q      <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (bank_we) begin
        bank_q <= bank_wd;
      end
    end
  end

  assign res_d = res_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q   <= req_e'(req_type_i);
      addr_q  <= bus_addr_i;
      wdata_q <= wdata_i;
      sw_a_q  <= switch_a_i;
      sw_b_q  <= switch_b_i;
    end
  end

  res_t res_new;

  always_ff @(posedge clk_i) begin
    res_q <= adv ? res_new : res_d;
  end

  sbbg_decode u_decode (
    .fire_i     (adv),
    .req_i      (req_q),
    .addr_i     (addr_q),
    .wdata_i    (wdata_q),
    .switch_a_i (sw_a_q),
    .switch_b_i (sw_b_q),
    .bank_i     (bank_q),
    .fifo_st_i  (fifo_st),
    .cv_old_i   (cv_old),
    .res_o      (res_new),
    .fifo_ctl_o (fifo_ctl),
    .cv_wr_o    (cv_wr),
    .bank_we_o  (bank_we),
    .bank_wd_o  (bank_wd)
  );

  sbbg_cv_store u_cv_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (cv_rd),
    .wr_i      (cv_wr),
    .rd_data_o (cv_old)
  );

  sbbg_rx_fifo #(
    .Depth (RX_FIFO_DEPTH)
  ) u_rx_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (fifo_ctl),
    .st_o   (fifo_st)
  );

  assign out_valid_o    = out_valid_q;
  assign target_o       = 3'(res_q.target);
  assign sub_index_o    = res_q.sub_index;
  assign timer_reg_o    = res_q.timer_reg;
  assign mapped_addr_o  = res_q.mapped_addr;
  assign rdata_o        = res_q.rdata;
  assign cv_value_o     = res_q.cv_value;
  assign led_value_o    = res_q.led_value;
  assign halt_request_o = res_q.halt_request;
  assign fault_flag_o   = res_q.fault_flag;
  assign rx_pending_o   = res_q.rx_pending;

endmodule

// ----- rtl/sbbg_checker.sv -----
// ----------------------------------------------------------------------------
// sbbg_checker
// Port-level checks on the bus glue, bound to the top level.
// ----------------------------------------------------------------------------
module sbbg_checker
  import sbbg_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  req_type_i,
  input logic [15:0] bus_addr_i,
  input logic [7:0]  wdata_i,
  input logic [7:0]  switch_a_i,
  input logic [7:0]  switch_b_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  target_o,
  input logic [5:0]  sub_index_o,
  input logic [1:0]  timer_reg_o,
  input logic [15:0] mapped_addr_o,
  input logic [7:0]  rdata_o,
  input logic [11:0] cv_value_o,
  input logic [7:0]  led_value_o,
  input logic        halt_request_o,
  input logic        fault_flag_o,
  input logic        rx_pending_o
);

  // Input side stalls only behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result side is free");

  // A stalled input word holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(req_type_i) &&
      $stable(bus_addr_i) && $stable(wdata_i) && $stable(switch_a_i) &&
      $stable(switch_b_i)))
    else $error("stalled input word changed");

  // A fresh result traces back to an accepted word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result appeared without an accepted word");

  // Stalled result holds its word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(target_o) &&
      $stable(sub_index_o) && $stable(timer_reg_o) && $stable(mapped_addr_o) &&
      $stable(rdata_o) && $stable(cv_value_o) && $stable(led_value_o) &&
      $stable(halt_request_o) && $stable(fault_flag_o) && $stable(rx_pending_o)))
    else $error("stalled result changed");

  // A DAC update is never flagged as a halt or a fault
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (target_o == TGT_DAC)) |-> (!fault_flag_o && !halt_request_o))
    else $error("DAC update flagged as fault or halt");

endmodule

bind synth_board_bus_glue sbbg_checker u_sbbg_checker (.*);
